FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the rANS byte encoder.
// No dependencies; take it with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising edge, off while reset is low
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

FILE: rtl/rbe_pkg.sv
// Shared types and constants of the rANS byte encoder.
// No dependencies; used by every module of the block.
`default_nettype none

package rbe_pkg;

  // Field widths
  localparam int unsigned StateW = 32;
  localparam int unsigned FreqW  = 17;
  localparam int unsigned StartW = 16;
  localparam int unsigned SymW   = 8;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned ScaleW = 5;
  localparam int unsigned KindW  = 2;

  // Scale register: reset value and largest legal value
  localparam logic [ScaleW-1:0] ScaleReset = 5'd14;
  localparam logic [ScaleW-1:0] ScaleMax   = 5'd16;

  // Divider iteration counter
  localparam int unsigned DivCntW = $clog2(StateW);

  // Input item kinds
  typedef enum logic [KindW-1:0] {
    KIND_ENCODE = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_e;

  // Symbol table access
  typedef struct packed {
    logic              we;
    logic              re;
    logic [SymW-1:0]   addr;
    logic [FreqW-1:0]  freq;
    logic [StartW-1:0] start;
  } tbl_req_t;

  typedef struct packed {
    logic [FreqW-1:0]  freq;
    logic [StartW-1:0] start;
  } tbl_rsp_t;

  // Serial divider handshake
  typedef struct packed {
    logic              start;
    logic [StateW-1:0] dividend;
    logic [FreqW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [StateW-1:0] quotient;
    logic [FreqW-1:0]  remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/rbe_table.sv
// Symbol table of the rANS byte encoder: frequency and cumulative start
// per symbol in one synchronous memory. Depends on rbe_pkg.
`default_nettype none

module rbe_table #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rbe_pkg::tbl_req_t req_i,
  output rbe_pkg::tbl_rsp_t      rsp_o
);

  localparam int unsigned AddrW  = $clog2(DEPTH);
  localparam int unsigned EntryW = rbe_pkg::FreqW + rbe_pkg::StartW;

  logic [AddrW-1:0]  idx;
  logic [EntryW-1:0] mem_q [DEPTH];
  logic [EntryW-1:0] rdata_q;
  logic [DEPTH-1:0]  valid_q;
  logic              rd_valid_q;

  assign idx = req_i.addr[AddrW-1:0];

  // Memory array: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[idx] <= {req_i.freq, req_i.start};
    end
    if (req_i.re) begin
      rdata_q <= mem_q[idx];
    end
  end

  // Per-entry valid bits; an entry never loaded reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[idx] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[idx];
      end
    end
  end

  assign rsp_o.freq  = rd_valid_q ? rdata_q[EntryW-1 -: rbe_pkg::FreqW] : '0;
  assign rsp_o.start = rd_valid_q ? rdata_q[rbe_pkg::StartW-1:0] : '0;

endmodule

`default_nettype wire

FILE: rtl/rbe_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle, 32-bit dividend
// by 17-bit divisor. Depends on rbe_pkg.
`default_nettype none

module rbe_divider (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rbe_pkg::div_req_t req_i,
  output rbe_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned SW = rbe_pkg::StateW;
  localparam int unsigned FW = rbe_pkg::FreqW;
  localparam logic [rbe_pkg::DivCntW-1:0] LastCnt = rbe_pkg::DivCntW'(SW - 1);

  logic                       busy_q;
  logic                       done_q;
  logic [rbe_pkg::DivCntW-1:0] cnt_q;
  logic [SW-1:0]              quo_q;
  logic [FW-1:0]              rem_q;
  logic [FW-1:0]              dsr_q;
  logic [FW:0]                shifted;
  logic [FW:0]                diff;
  logic                       ge;

  // One trial subtraction per cycle
  always_comb begin
    shifted = {rem_q, quo_q[SW-1]};
    diff    = shifted - {1'b0, dsr_q};
    ge      = shifted >= {1'b0, dsr_q};
  end

  // Sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[SW-2:0], ge};
      rem_q <= ge ? diff[FW-1:0] : shifted[FW-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

FILE: rtl/rans_byte_encoder_core.sv
// rANS byte encoder, top level: sequencer, coder state, output register.
// Depends on rbe_pkg, rbe_table and rbe_divider.
//
// Use: write the scale register (log2 of the total frequency) through
// cfg_we_i/cfg_wdata_i while idle. Load the
// symbol table with load transactions (kind 1), then send encode
// transactions (kind 0) in reverse symbol order and end with a flush
// (kind 2). Each byte leaves as one output transaction; last_o marks the
// final byte of an input transaction, error_o a zero-frequency symbol.
// The byte stream comes out back to front; the consumer reverses it.
// Timing: a load or unused kind is handled in S_IDLE, which stays ready.
// A flush emits its four bytes, waiting on any output stall. An encode
// goes through S_READ, then S_RENORM for k = 0..3 renormalization bytes,
// then the serial divider, one quotient bit per cycle, which sets the rate
// along with output stalls. A zero-frequency encode ends in S_ERR instead.
// Reset: coder state 2^LOWER_BOUND_LOG, scale 14, table reads zero
// at once through per-entry valid bits (no clearing pass).
// Stall: one output register holds a byte until taken; the sequencer waits
// on it, and in_ready_o stays low while an encode or flush is in progress.
`default_nettype none

module rans_byte_encoder_core #(
  parameter int unsigned ALPHABET_SIZE   = 256,
  parameter int unsigned LOWER_BOUND_LOG = 23
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [rbe_pkg::ScaleW-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [rbe_pkg::KindW-1:0]     kind_i,
  input  wire logic [rbe_pkg::SymW-1:0]      symbol_i,
  input  wire logic [rbe_pkg::FreqW-1:0]     frequency_i,
  input  wire logic [rbe_pkg::StartW-1:0]    cumulative_start_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [rbe_pkg::ByteW-1:0]          out_byte_o,
  output logic                               last_o,
  output logic                               error_o
);

  localparam int unsigned SW    = rbe_pkg::StateW;
  localparam int unsigned FW    = rbe_pkg::FreqW;
  localparam int unsigned BW    = rbe_pkg::ByteW;
  // Bound x_max = f << (LOWER_BOUND_LOG + 8 - scale), widest at scale 1
  localparam int unsigned XMaxW = FW + LOWER_BOUND_LOG + 7;
  localparam logic [SW-1:0] StateInit = SW'(1) << LOWER_BOUND_LOG;
  localparam logic [5:0] BoundShift = 6'(LOWER_BOUND_LOG + 8);
  localparam logic [1:0] FlushLast = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ERR,
    S_RENORM,
    S_DIV,
    S_FLUSH
  } state_e;

  state_e                        state_q, state_d;
  logic [SW-1:0]                 x_q, x_d;
  logic [rbe_pkg::ScaleW-1:0]    scale_q, scale_d;
  logic [FW-1:0]                 f_q, f_d;
  logic [rbe_pkg::StartW-1:0]    start_q, start_d;
  logic [XMaxW-1:0]              xmax_q, xmax_d;
  logic                          sym_ok_q, sym_ok_d;
  logic [1:0]                    cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;
  logic [BW-1:0]                 out_byte_q, out_byte_d;
  logic                          out_last_q, out_last_d;
  logic                          out_err_q, out_err_d;

  rbe_pkg::tbl_req_t             tbl_req;
  rbe_pkg::tbl_rsp_t             tbl_rsp;
  rbe_pkg::div_req_t             div_req;
  rbe_pkg::div_rsp_t             div_rsp;

  logic                          sym_ok;
  logic                          slot_free;
  logic [rbe_pkg::ScaleW-1:0]    eff_scale;
  logic [5:0]                    shift_amt;
  logic [FW-1:0]                 f_rd;
  logic [XMaxW-1:0]              x_ext;
  logic [XMaxW-1:0]              x_next_ext;
  logic [SW-1:0]                 fold;

  rbe_table #(
    .DEPTH (ALPHABET_SIZE)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  rbe_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Helpers
  always_comb begin
    sym_ok    = {1'b0, symbol_i} < 9'(ALPHABET_SIZE);
    slot_free = !out_valid_q || out_ready_i;
    eff_scale = (scale_q == '0 || scale_q > rbe_pkg::ScaleMax) ? rbe_pkg::ScaleReset
                                                               : scale_q;
    shift_amt = BoundShift - {1'b0, eff_scale};
    f_rd      = sym_ok_q ? tbl_rsp.freq : '0;
    x_ext      = XMaxW'(x_q);
    x_next_ext = XMaxW'(x_q >> BW);
    fold       = (div_rsp.quotient << eff_scale) + SW'(div_rsp.remainder) + SW'(start_q);
  end

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    scale_d     = cfg_we_i ? cfg_wdata_i : scale_q;
    f_d         = f_q;
    start_d     = start_q;
    xmax_d      = xmax_q;
    sym_ok_d    = sym_ok_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;

    tbl_req.we    = 1'b0;
    tbl_req.re    = 1'b0;
    tbl_req.addr  = symbol_i;
    tbl_req.freq  = frequency_i;
    tbl_req.start = cumulative_start_i;

    div_req.start    = 1'b0;
    div_req.dividend = x_q;
    div_req.divisor  = f_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (rbe_pkg::kind_e'(kind_i))
            rbe_pkg::KIND_LOAD: begin
              tbl_req.we = sym_ok;
            end
            rbe_pkg::KIND_ENCODE: begin
              tbl_req.re = 1'b1;
              sym_ok_d   = sym_ok;
              state_d    = S_READ;
            end
            rbe_pkg::KIND_FLUSH: begin
              cnt_d   = '0;
              state_d = S_FLUSH;
            end
            default: ;
          endcase
        end
      end

      // Table data is in; form the renormalization bound
      S_READ: begin
        f_d     = f_rd;
        start_d = tbl_rsp.start;
        xmax_d  = XMaxW'(f_rd) << shift_amt;
        state_d = (f_rd == '0) ? S_ERR : S_RENORM;
      end

      S_ERR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = '0;
          out_last_d  = 1'b1;
          out_err_d   = 1'b1;
          state_d     = S_IDLE;
        end
      end

      // Emit low bytes while the state is at or above the bound
      S_RENORM: begin
        if (x_ext >= xmax_q) begin
          if (slot_free) begin
            out_valid_d = 1'b1;
            out_byte_d  = x_q[BW-1:0];
            out_last_d  = x_next_ext < xmax_q;
            out_err_d   = 1'b0;
            x_d         = x_q >> BW;
          end
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end
      end

      // Fold the symbol in once the quotient is ready
      S_DIV: begin
        if (div_rsp.done) begin
          x_d     = fold;
          state_d = S_IDLE;
        end
      end

      // Four bytes, high byte first, then back to the initial state
      S_FLUSH: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = x_q[SW-1 -: BW];
          out_last_d  = cnt_q == FlushLast;
          out_err_d   = 1'b0;
          x_d         = {x_q[SW-BW-1:0], {BW{1'b0}}};
          cnt_d       = cnt_q + 1'b1;
          if (cnt_q == FlushLast) begin
            x_d     = StateInit;
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      x_q         <= StateInit;
      scale_q     <= rbe_pkg::ScaleReset;
      f_q         <= '0;
      start_q     <= '0;
      xmax_q      <= '0;
      sym_ok_q    <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      scale_q     <= scale_d;
      f_q         <= f_d;
      start_q     <= start_d;
      xmax_q      <= xmax_d;
      sym_ok_q    <= sym_ok_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
      out_err_q   <= out_err_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = out_last_q;
  assign error_o     = out_err_q;

endmodule

`default_nettype wire

FILE: rtl/rbe_checker.sv
// Port-level checker for the rANS byte encoder and its bind to the top.
// Depends on rbe_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rbe_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic [rbe_pkg::KindW-1:0]  kind_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [rbe_pkg::ByteW-1:0]  out_byte_o,
  input wire logic                       last_o,
  input wire logic                       error_o
);

  logic in_fire;
  logic busy_kind;

  assign in_fire   = in_valid_i && in_ready_o;
  assign busy_kind = (kind_i == rbe_pkg::KIND_ENCODE) || (kind_i == rbe_pkg::KIND_FLUSH);

  // A stalled result holds its payload
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_byte_o) && $stable(last_o) && $stable(error_o), "stalled result changed")

  // Encode and flush transactions occupy the sequencer
  `ASSERT_NEXT(a_busy_after, clk_i, rst_ni, in_fire && busy_kind, !in_ready_o, "ready after encode or flush")

  // Load and unused kinds leave the sequencer ready in the next cycle
  `ASSERT_NEXT(a_load_quick, clk_i, rst_ni, in_fire && !busy_kind, in_ready_o, "not ready after load")

  // An error result is a single zero byte that closes its transaction
  `ASSERT_IMPL(a_err_form, clk_i, rst_ni, out_valid_o && error_o, last_o && (out_byte_o == '0), "malformed error result")

endmodule

bind rans_byte_encoder_core rbe_checker u_rbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .last_o      (last_o),
  .error_o     (error_o)
);

`default_nettype wire
